@@ hw/rtl/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared widths, constants and control types of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HUE_W  = 16;
  localparam int unsigned CHAN_W = 8;

  // One full unit of the q and t numerators: 255 * 65536.
  localparam logic [23:0] FULL_SCALE = 24'd16711680;

  localparam logic [2:0] SECTOR_RED     = 3'd0;
  localparam logic [2:0] SECTOR_YELLOW  = 3'd1;
  localparam logic [2:0] SECTOR_GREEN   = 3'd2;
  localparam logic [2:0] SECTOR_CYAN    = 3'd3;
  localparam logic [2:0] SECTOR_BLUE    = 3'd4;
  localparam logic [2:0] SECTOR_MAGENTA = 3'd5;

  typedef struct packed {
    logic est;
    logic fix;
  } div_ctrl_t;

endpackage

@@ hw/rtl/hsv2rgb_if.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB channel interfaces
// Valid/ready channels for the HSV request and the RGB result.
// ----------------------------------------------------------------------------
interface hsv2rgb_hsv_if;
  logic                              valid;
  logic                              ready;
  logic [hsv2rgb_pkg::HUE_W-1:0]     hue;
  logic [hsv2rgb_pkg::CHAN_W-1:0]    saturation;
  logic [hsv2rgb_pkg::CHAN_W-1:0]    brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if;
  logic                              valid;
  logic                              ready;
  logic [hsv2rgb_pkg::CHAN_W-1:0]    red;
  logic [hsv2rgb_pkg::CHAN_W-1:0]    green;
  logic [hsv2rgb_pkg::CHAN_W-1:0]    blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

@@ hw/rtl/hsv_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts a 16-bit hue with 8-bit saturation and brightness to 8-bit RGB.
//
// The hsv channel takes one request per cycle while ready: hue is a fraction
// of a full turn in units of 1/65536, saturation and brightness are in units
// of 1/255. The rgb channel returns one result per request, in request order.
// The work runs in a five-stage pipeline: hue scaling, the f*s products,
// the brightness products, the reciprocal estimate of the division by 255,
// and its correction together with the sector routing.
// One request per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// lowers hsv.ready only once every stage holds a request; nothing is lost
// or repeated.
// Synchronous reset empties the pipeline; payload registers keep their data.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic                 clk,
  input  logic                 rst,
  hsv2rgb_hsv_if.sink          hsv,
  hsv2rgb_rgb_if.source        rgb
);

  logic [4:0] v;
  logic [4:0] en;

  assign en[4] = !v[4] || rgb.ready;
  assign en[3] = !v[3] || en[4];
  assign en[2] = !v[2] || en[3];
  assign en[1] = !v[1] || en[2];
  assign en[0] = !v[0] || en[1];

  assign hsv.ready = en[0];
  assign rgb.valid = v[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= hsv.valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
    end
  end

  // Stage A: hue times six, and b * (255 - s).
  logic [18:0] h6;
  logic [15:0] ps_next;
  logic [2:0]  a_sector;
  logic [15:0] a_frac;
  logic [7:0]  a_sat;
  logic [7:0]  a_bri;
  logic [15:0] a_ps;

  assign h6      = {1'b0, hsv.hue, 2'b00} + {2'b00, hsv.hue, 1'b0};
  assign ps_next = {8'h00, hsv.brightness} * {8'h00, 8'd255 - hsv.saturation};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_sector <= h6[18:16];
      a_frac   <= h6[15:0];
      a_sat    <= hsv.saturation;
      a_bri    <= hsv.brightness;
      a_ps     <= ps_next;
    end
  end

  // Stage B: numerators of q and t.
  logic [23:0] fs;
  logic [16:0] inv_frac;
  logic [24:0] gs;
  logic [2:0]  b_sector;
  logic [7:0]  b_bri;
  logic [15:0] b_ps;
  logic [23:0] b_nq;
  logic [23:0] b_nt;

  assign fs       = {8'h00, a_frac} * {16'h0000, a_sat};
  assign inv_frac = 17'h10000 - {1'b0, a_frac};
  assign gs       = {8'h00, inv_frac} * {17'h00000, a_sat};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_sector <= a_sector;
      b_bri    <= a_bri;
      b_ps     <= a_ps;
      b_nq     <= hsv2rgb_pkg::FULL_SCALE - fs;
      b_nt     <= hsv2rgb_pkg::FULL_SCALE - gs[23:0];
    end
  end

  // Stage C: brightness products, pre-divided by 65536.
  logic [31:0] mq;
  logic [31:0] mt;
  logic [2:0]  c_sector;
  logic [7:0]  c_bri;
  logic [15:0] c_ps;
  logic [15:0] c_mq;
  logic [15:0] c_mt;

  assign mq = {24'h000000, b_bri} * {8'h00, b_nq};
  assign mt = {24'h000000, b_bri} * {8'h00, b_nt};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_sector <= b_sector;
      c_bri    <= b_bri;
      c_ps     <= b_ps;
      c_mq     <= mq[31:16];
      c_mt     <= mt[31:16];
    end
  end

  // Stages D and E: division by 255, then routing.
  hsv2rgb_pkg::div_ctrl_t div_ctrl;
  logic [7:0] p_val;
  logic [7:0] q_val;
  logic [7:0] t_val;
  logic [2:0] d_sector;
  logic [7:0] d_bri;
  logic [2:0] e_sector;
  logic [7:0] e_bri;

  assign div_ctrl.est = en[3];
  assign div_ctrl.fix = en[4];

  hsv2rgb_div255 u_div_p (.clk(clk), .ctrl(div_ctrl), .x(c_ps), .quotient(p_val));
  hsv2rgb_div255 u_div_q (.clk(clk), .ctrl(div_ctrl), .x(c_mq), .quotient(q_val));
  hsv2rgb_div255 u_div_t (.clk(clk), .ctrl(div_ctrl), .x(c_mt), .quotient(t_val));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d_sector <= c_sector;
      d_bri    <= c_bri;
    end
    if (en[4]) begin
      e_sector <= d_sector;
      e_bri    <= d_bri;
    end
  end

  always_comb begin
    unique case (e_sector)
      hsv2rgb_pkg::SECTOR_YELLOW: begin
        rgb.red = q_val; rgb.green = e_bri; rgb.blue = p_val;
      end
      hsv2rgb_pkg::SECTOR_GREEN: begin
        rgb.red = p_val; rgb.green = e_bri; rgb.blue = t_val;
      end
      hsv2rgb_pkg::SECTOR_CYAN: begin
        rgb.red = p_val; rgb.green = q_val; rgb.blue = e_bri;
      end
      hsv2rgb_pkg::SECTOR_BLUE: begin
        rgb.red = t_val; rgb.green = p_val; rgb.blue = e_bri;
      end
      hsv2rgb_pkg::SECTOR_MAGENTA: begin
        rgb.red = e_bri; rgb.green = p_val; rgb.blue = q_val;
      end
      default: begin
        rgb.red = e_bri; rgb.green = t_val; rgb.blue = p_val;
      end
    endcase
  end

  // The input side stalls only when every stage is full and the output waits.
  assert property (@(posedge clk) !hsv.ready |-> ((&v) && !rgb.ready))
    else $error("hsv.ready low while the pipeline has room");

  // Reset empties every stage.
  assert property (@(posedge clk) rst |=> (v == 5'b00000))
    else $error("pipeline not empty after reset");

  // One channel of every result carries the brightness unchanged.
  assert property (@(posedge clk) disable iff (rst)
    rgb.valid |-> (rgb.red == e_bri || rgb.green == e_bri || rgb.blue == e_bri))
    else $error("no channel carries the brightness");

endmodule

@@ hw/rtl/hsv2rgb_div255.sv @@
// ----------------------------------------------------------------------------
// Divide by 255
// Two-stage pipelined floor(x / 255) for a 16-bit x whose quotient fits
// in 8 bits: a reciprocal estimate, then one compare and correct step.
// ----------------------------------------------------------------------------
module hsv2rgb_div255 (
  input  logic                   clk,
  input  hsv2rgb_pkg::div_ctrl_t ctrl,
  input  logic [15:0]            x,
  output logic [7:0]             quotient
);

  logic [24:0] prod;
  logic [15:0] x_est;
  logic [8:0]  q_est;
  logic [16:0] q_times;
  logic [16:0] rem;

  assign prod    = {1'b0, x, 8'h00} + {9'h000, x};
  assign q_times = {q_est, 8'h00} - {8'h00, q_est};
  assign rem     = {1'b0, x_est} - q_times;

  always_ff @(posedge clk) begin
    if (ctrl.est) begin
      x_est <= x;
      q_est <= prod[24:16];
    end
    if (ctrl.fix) begin
      quotient <= q_est[7:0] + {7'h00, (rem >= 17'd255)};
    end
  end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Sends hue, saturation and brightness requests through the valid/ready
// channel and compares every RGB result, field by field, against a fixed
// point predictor kept in the bench. Directed requests cover the field
// extremes, every hue sector with its boundaries, and grey and black
// inputs. Random traffic then runs with and without sender idles and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 125;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_pixel_t;

  logic clk = 1'b0;
  logic rst;

  hsv2rgb_hsv_if hsv_bus ();
  hsv2rgb_rgb_if rgb_bus ();

  hsv_to_rgb_converter DUT (
    .clk (clk),
    .rst (rst),
    .hsv (hsv_bus),
    .rgb (rgb_bus)
  );

  rgb_pixel_t  expected_pixels[$];
  int unsigned request_count = 0;
  int unsigned pixel_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sector_hits[6];
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic rgb_pixel_t predict_pixel(input logic [HUE_W-1:0] hue,
                                               input logic [CHAN_W-1:0] sat,
                                               input logic [CHAN_W-1:0] bri,
                                               output logic [2:0] sector);
    longint unsigned h6, frac, s, b, full, v, p, q, t;
    rgb_pixel_t px;
    h6 = hue;
    h6 = h6 * 6;
    sector = 3'(h6 >> 16);
    frac = h6 & 64'hFFFF;
    s = sat;
    b = bri;
    full = FULL_SCALE;
    v = b;
    p = b * (255 - s) / 255;
    q = b * (full - frac * s) / full;
    t = b * (full - (65536 - frac) * s) / full;
    case (sector)
      SECTOR_YELLOW:  px = '{CHAN_W'(q), CHAN_W'(v), CHAN_W'(p)};
      SECTOR_GREEN:   px = '{CHAN_W'(p), CHAN_W'(v), CHAN_W'(t)};
      SECTOR_CYAN:    px = '{CHAN_W'(p), CHAN_W'(q), CHAN_W'(v)};
      SECTOR_BLUE:    px = '{CHAN_W'(t), CHAN_W'(p), CHAN_W'(v)};
      SECTOR_MAGENTA: px = '{CHAN_W'(v), CHAN_W'(p), CHAN_W'(q)};
      default:        px = '{CHAN_W'(v), CHAN_W'(t), CHAN_W'(p)};
    endcase
    return px;
  endfunction

  always @(negedge clk) begin
    rgb_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    rgb_pixel_t want;
    logic [2:0] sector;
    if (!rst) begin
      if (hsv_bus.valid && hsv_bus.ready) begin
        want = predict_pixel(hsv_bus.hue, hsv_bus.saturation, hsv_bus.brightness, sector);
        expected_pixels.push_back(want);
        sector_hits[sector]++;
        request_count++;
      end
      if (rgb_bus.valid && rgb_bus.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: red %0d green %0d blue %0d",
                 rgb_bus.red, rgb_bus.green, rgb_bus.blue);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          pixel_count++;
          if (rgb_bus.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, rgb_bus.red);
            error_count++;
          end
          if (rgb_bus.green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, rgb_bus.green);
            error_count++;
          end
          if (rgb_bus.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, rgb_bus.blue);
            error_count++;
          end
        end
      end
    end
  end

  task automatic send_request(input logic [HUE_W-1:0] hue, input logic [CHAN_W-1:0] sat,
                              input logic [CHAN_W-1:0] bri);
    @(negedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      hsv_bus.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    hsv_bus.valid      <= 1'b1;
    hsv_bus.hue        <= hue;
    hsv_bus.saturation <= sat;
    hsv_bus.brightness <= bri;
    do @(posedge clk); while (!hsv_bus.ready);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    hsv_bus.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset();
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  endtask

  task automatic test_field_extremes();
    send_request(16'h0000, 8'hFF, 8'hFF);
    send_request(16'hFFFF, 8'hFF, 8'hFF);
    send_request(16'hFFFF, 8'h00, 8'h00);
    send_request(16'h5555, 8'hAA, 8'h55);
    send_request(16'hAAAA, 8'h55, 8'hAA);
    send_request(16'h8000, 8'hFF, 8'h00);
  endtask

  task automatic test_sector_boundaries();
    send_request(16'd10922, 8'hFF, 8'hFF);
    send_request(16'd10923, 8'hFF, 8'hFF);
    send_request(16'd21845, 8'hFF, 8'hFF);
    send_request(16'd21846, 8'hFF, 8'hFF);
    send_request(16'd32767, 8'hFF, 8'hFF);
    send_request(16'd32768, 8'hFF, 8'hFF);
    send_request(16'd43690, 8'hFF, 8'hFF);
    send_request(16'd43691, 8'hFF, 8'hFF);
    send_request(16'd54613, 8'hFF, 8'hFF);
    send_request(16'd54614, 8'hFF, 8'hFF);
    for (int k = 0; k < 6; k++) begin
      send_request(HUE_W'(k * 10923 + 5461), 8'd200, 8'd180);
    end
  endtask

  task automatic test_grey_levels();
    send_request(16'd0, 8'd0, 8'd255);
    send_request(16'd40000, 8'd0, 8'd128);
    send_request(16'd60000, 8'd0, 8'd1);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] bri;
    int                k;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (RANDOM_PER_PHASE) begin
      if ($urandom_range(4) == 0) begin
        k = $urandom_range(5);
        hue = HUE_W'((k * 65536 + 5) / 6 + $urandom_range(4) - 2);
      end else begin
        hue = HUE_W'($urandom);
      end
      case ($urandom_range(9))
        0:       sat = 8'h00;
        1:       sat = 8'hFF;
        default: sat = CHAN_W'($urandom);
      endcase
      case ($urandom_range(9))
        0:       bri = 8'h00;
        1:       bri = 8'hFF;
        default: bri = CHAN_W'($urandom);
      endcase
      send_request(hue, sat, bri);
    end
    wait_for_results();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    hsv_bus.valid      = 1'b0;
    hsv_bus.hue        = '0;
    hsv_bus.saturation = '0;
    hsv_bus.brightness = '0;
    rgb_bus.ready      = 1'b0;
    test_reset();
    test_field_extremes();
    test_sector_boundaries();
    test_grey_levels();
    wait_for_results();
    test_random_traffic(0, 0);
    test_random_traffic(60, 0);
    test_random_traffic(0, 60);
    test_random_traffic(29, 29);
    $display("Checked %0d results for %0d requests over four idle and stall phases.",
             pixel_count, request_count);
    $display("Requests per hue sector: %0d %0d %0d %0d %0d %0d; %0d errors.",
             sector_hits[0], sector_hits[1], sector_hits[2], sector_hits[3],
             sector_hits[4], sector_hits[5], error_count);
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_if.sv
hw/rtl/hsv2rgb_div255.sv
hw/rtl/hsv_to_rgb_converter.sv
verif/testbench.sv
